>>> src/timed_address_admission_table_macros.svh
// Assertion macros for the timed address admission table.
// Used by the top level only; expects signals clk and rst in scope.
`ifndef TIMED_ADDRESS_ADMISSION_TABLE_MACROS_SVH
`define TIMED_ADDRESS_ADMISSION_TABLE_MACROS_SVH

// Check a property on every rising edge outside reset.
`define TAAT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define TAAT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/taat_pkg.sv
// Shared types and constants for the timed address admission table.
// No dependencies; used by taat_entry_ram, taat_ctrl and the top level.
package taat_pkg;

  localparam int ENTRIES_DEFAULT = 64;
  localparam logic [31:0] HOLD_MS_RESET = 32'd30000;

  // Operation codes
  localparam logic FUNC_ADD = 1'b0;
  localparam logic FUNC_DEL = 1'b1;

  // Result codes
  localparam logic [1:0] ST_ADDED   = 2'd0;
  localparam logic [1:0] ST_DUP     = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_DELETED = 2'd3;

  // One table slot as stored in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [31:0] expiry;
  } entry_t;

endpackage

>>> src/taat_entry_ram.sv
// Slot memory: one write port and one registered read port.
// Depends on taat_pkg for the slot type.
module taat_entry_ram #(
  parameter int ENTRIES = taat_pkg::ENTRIES_DEFAULT,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [IDX_W-1:0]     waddr,
  input  taat_pkg::entry_t     wdata,
  input  logic                 re,
  input  logic [IDX_W-1:0]     raddr,
  output taat_pkg::entry_t     rdata
);

  taat_pkg::entry_t mem [ENTRIES];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/taat_ctrl.sv
// Scan sequencer: clears the table after reset, then walks every slot per word
// with read-modify-write, an add stopping at a live duplicate. Depends on taat_pkg.
module taat_ctrl #(
  parameter int ENTRIES = taat_pkg::ENTRIES_DEFAULT,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int CNT_W = IDX_W + 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              func,
  input  logic [31:0]       addr_key,
  input  logic [31:0]       now_ms,
  input  logic [31:0]       hold,
  input  logic              out_free,
  output logic              busy,
  output logic              mem_re,
  output logic [IDX_W-1:0]  mem_raddr,
  input  taat_pkg::entry_t  mem_rdata,
  output logic              mem_we,
  output logic [IDX_W-1:0]  mem_waddr,
  output taat_pkg::entry_t  mem_wdata,
  output logic              res_load,
  output logic [1:0]        res_status
);

  localparam logic [1:0] S_CLEAR  = 2'd0;
  localparam logic [1:0] S_IDLE   = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] DEPTH    = CNT_W'(ENTRIES);

  logic [1:0]       state;
  logic [IDX_W-1:0] clr_idx;
  logic [CNT_W-1:0] rd_cnt;
  logic             rd_vld;
  logic [IDX_W-1:0] ev_idx;
  logic             cur_func;
  logic [31:0]      cur_key;
  logic [31:0]      cur_now;
  logic             slot_hit;
  logic [IDX_W-1:0] slot_idx;
  logic             dup_hit;

  logic issue;
  logic ev_active;
  logic ent_exp;
  logic ent_match;
  logic ent_free;
  logic dup_now;
  logic clear_now;
  logic last_now;

  // Slot evaluation on the word returned by the memory
  assign issue     = (state == S_SCAN) && (rd_cnt < DEPTH);
  assign ev_active = (state == S_SCAN) && rd_vld;
  assign ent_exp   = mem_rdata.valid && (cur_now > mem_rdata.expiry);
  assign ent_match = mem_rdata.valid && (mem_rdata.key == cur_key);
  assign ent_free  = !mem_rdata.valid || ent_exp;
  assign dup_now   = ev_active && (cur_func == taat_pkg::FUNC_ADD) && !ent_exp && ent_match;
  assign clear_now = ev_active &&
                     ((cur_func == taat_pkg::FUNC_DEL) ? ent_match : ent_exp);
  assign last_now  = ev_active && (ev_idx == LAST_IDX);

  assign busy      = (state != S_IDLE);
  assign mem_re    = issue;
  assign mem_raddr = rd_cnt[IDX_W-1:0];
  assign res_load  = (state == S_FINISH) && out_free;

  // Result code for the word in flight
  always_comb begin
    if (cur_func == taat_pkg::FUNC_DEL) begin
      res_status = taat_pkg::ST_DELETED;
    end else if (dup_hit) begin
      res_status = taat_pkg::ST_DUP;
    end else if (slot_hit) begin
      res_status = taat_pkg::ST_ADDED;
    end else begin
      res_status = taat_pkg::ST_FULL;
    end
  end

  // Memory write source per state
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ev_idx;
    mem_wdata = '{valid: 1'b0, key: mem_rdata.key, expiry: mem_rdata.expiry};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx;
        mem_wdata = '0;
      end
      S_SCAN: begin
        mem_we = clear_now;
      end
      S_FINISH: begin
        mem_we    = res_load && (cur_func == taat_pkg::FUNC_ADD) && !dup_hit && slot_hit;
        mem_waddr = slot_idx;
        mem_wdata = '{valid: 1'b1, key: cur_key, expiry: cur_now + hold};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
      rd_vld  <= 1'b0;
    end else begin
      rd_vld <= issue && !dup_now;
      ev_idx <= mem_raddr;
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_IDX) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur_func <= func;
            cur_key  <= addr_key;
            cur_now  <= now_ms;
            rd_cnt   <= '0;
            slot_hit <= 1'b0;
            dup_hit  <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_cnt <= rd_cnt + 1'b1;
          end
          // take the lowest empty or expired slot
          if (ev_active && (cur_func == taat_pkg::FUNC_ADD) && !slot_hit && ent_free) begin
            slot_hit <= 1'b1;
            slot_idx <= ev_idx;
          end
          if (dup_now) begin
            dup_hit <= 1'b1;
            state   <= S_FINISH;
          end else if (last_now) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/timed_address_admission_table.sv
// Timed address admission table. Each input word (add or delete of a 32-bit
// key) is handled by a scan of every slot in the slot memory, one slot read
// per cycle through the single read port of the slot memory, with the freed
// slots written back behind the read; an add that meets a live duplicate ends
// its scan there. One word is in work at a time; a finished status waits in
// an output register. After reset the block runs a clearing pass over every
// slot before it takes a word; hold_ms writes are taken at any time (ready
// is always high).
// Depends on taat_pkg, taat_ctrl, taat_entry_ram and the macros header.
`include "timed_address_admission_table_macros.svh"

module timed_address_admission_table #(
  parameter int ENTRIES = taat_pkg::ENTRIES_DEFAULT,
  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        func,
  input  logic [31:0] addr_key,
  input  logic [31:0] now_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] hold_ms
);

  logic             hold;
  logic [31:0]      hold_val;
  logic             out_free;
  logic             start;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  taat_pkg::entry_t mem_wdata;
  taat_pkg::entry_t mem_rdata;
  logic             res_load;
  logic [1:0]       res_status;

  assign cfg_ready = 1'b1;
  assign hold      = cfg_valid && cfg_ready;
  assign start     = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Hold time register
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_val <= taat_pkg::HOLD_MS_RESET;
    end else if (hold) begin
      hold_val <= hold_ms;
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status <= res_status;
    end
  end

  taat_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .func       (func),
    .addr_key   (addr_key),
    .now_ms     (now_ms),
    .hold       (hold_val),
    .out_free   (out_free),
    .busy       (in_stall),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .res_load   (res_load),
    .res_status (res_status)
  );

  taat_entry_ram #(
    .ENTRIES(ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // A write-back never lands on the slot being read in the same cycle
  `TAAT_ASSERT(a_no_rw_collision, mem_we && mem_re |-> mem_waddr != mem_raddr, "write-back hits slot under read")
  // An accepted word blocks the input until its status is loaded
  `TAAT_ASSERT(a_busy_after_accept, start |=> in_stall, "input open during a scan")
  // Reset always starts the clearing pass with the input closed
  `TAAT_ASSERT_ALWAYS(a_stall_after_reset, rst |=> in_stall, "input open right after reset")
  // A result is only loaded while no word is being accepted
  `TAAT_ASSERT(a_load_not_accept, res_load |-> !start, "result loaded while accepting a word")

endmodule

>>> verif/tb_timed_address_admission_table.sv
`timescale 1ns / 1ps
// Testbench for timed_address_admission_table: random and directed add/delete words,
// checked against a slot-table predictor held in a small scoreboard class.
// Depends on taat_pkg and the timed_address_admission_table top level.
module tb_timed_address_admission_table;

  localparam int SLOTS = taat_pkg::ENTRIES_DEFAULT;
  localparam int KEY_POOL_SIZE = 96;
  localparam int BLOCK_COUNT = 8;
  localparam int BLOCK_WORDS = 206;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 5000;

  // Predicts the status of each admission word and holds the ones still due
  class admission_scoreboard;
    logic [31:0] hold_len;
    bit          slot_live [SLOTS];
    logic [31:0] slot_key [SLOTS];
    logic [31:0] slot_expiry [SLOTS];
    logic [1:0]  due_status [$];
    int          mismatches;

    function new();
      hold_len = taat_pkg::HOLD_MS_RESET;
      foreach (slot_live[n]) slot_live[n] = 1'b0;
      mismatches = 0;
    endfunction

    function void set_hold(logic [31:0] value);
      hold_len = value;
    endfunction

    function int due_count();
      return due_status.size();
    endfunction

    // Scan every slot the way the block does and queue the status it owes
    function void note_request(logic op, logic [31:0] key, logic [31:0] now);
      int          slot;
      bit          hit;
      logic [1:0]  verdict;
      slot = -1;
      hit = 1'b0;
      if (op == taat_pkg::FUNC_DEL) begin
        for (int n = 0; n < SLOTS; n++) begin
          if (slot_live[n] && slot_key[n] == key) slot_live[n] = 1'b0;
        end
        verdict = taat_pkg::ST_DELETED;
      end else begin
        for (int n = 0; n < SLOTS; n++) begin
          if (!hit) begin
            if (slot_live[n]) begin
              // free an expired slot on the spot; a live match stops the scan
              if (now > slot_expiry[n]) begin
                slot_live[n] = 1'b0;
                if (slot < 0) slot = n;
              end else if (slot_key[n] == key) begin
                hit = 1'b1;
              end
            end else if (slot < 0) begin
              slot = n;
            end
          end
        end
        if (hit) begin
          verdict = taat_pkg::ST_DUP;
        end else if (slot < 0) begin
          verdict = taat_pkg::ST_FULL;
        end else begin
          slot_live[slot] = 1'b1;
          slot_key[slot] = key;
          slot_expiry[slot] = now + hold_len;
          verdict = taat_pkg::ST_ADDED;
        end
      end
      due_status.push_back(verdict);
    endfunction

    // Compare one status word with the oldest one due
    function void check_status(logic [1:0] got);
      logic [1:0] want;
      if (due_status.size() == 0) begin
        $error("status: expected none, actual %0d", got);
        mismatches++;
      end else begin
        want = due_status.pop_front();
        if (got !== want) begin
          $error("status: expected %0d, actual %0d", want, got);
          mismatches++;
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        func;
  logic [31:0] addr_key;
  logic [31:0] now_ms;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] hold_ms;

  admission_scoreboard sb = new();

  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_off_req = 0;
  int          hold_off_ack = 0;
  int          hold_off_left = 0;
  int          idle_cycles = 0;
  logic [31:0] clock_ms = 0;
  logic [31:0] key_pool [KEY_POOL_SIZE];
  logic [31:0] block_hold [BLOCK_COUNT] = '{32'd200, 32'd1, 32'hFFFF_FFFF, 32'd120,
                                            32'd30000, 32'd64, 32'd500, 32'd90};

  timed_address_admission_table #(.ENTRIES(SLOTS)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .func      (func),
    .addr_key  (addr_key),
    .now_ms    (now_ms),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .hold_ms   (hold_ms)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Take status words; stall at random or through a requested long hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_status(status);
    if (hold_off_req != hold_off_ack) begin
      hold_off_ack = hold_off_req;
      hold_off_left = LONG_HOLD_CYCLES;
    end
    if (hold_off_left > 0) begin
      hold_off_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // End the run when no word moves on any channel for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word after a random gap and hold it until taken
  task automatic send_request(input logic op, input logic [31:0] key, input logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= op;
    addr_key <= key;
    now_ms <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, key, now);
  endtask

  // Stop offering and wait until every due status has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (sb.due_count() != 0) @(posedge clk);
  endtask

  task automatic write_hold(input logic [31:0] value);
    cfg_valid <= 1'b1;
    hold_ms <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_hold(value);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pool keys on a slowly advancing clock, with some noise words
  task automatic run_block(input int words);
    int          roll;
    logic        op;
    logic [31:0] key;
    for (int i = 0; i < words; i++) begin
      roll = $urandom_range(99);
      if (roll < 8) begin
        send_request(1'($urandom_range(1)), $urandom, $urandom);
      end else begin
        roll = $urandom_range(99);
        if (roll < 2) clock_ms = $urandom;
        else if (roll < 4) clock_ms = 32'hFFFF_FFF0 + $urandom_range(15);
        else clock_ms = clock_ms + $urandom_range(3);
        op = ($urandom_range(99) < 18) ? taat_pkg::FUNC_DEL : taat_pkg::FUNC_ADD;
        key = key_pool[$urandom_range(KEY_POOL_SIZE - 1)];
        send_request(op, key, clock_ms);
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= taat_pkg::FUNC_ADD;
    addr_key <= '0;
    now_ms <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    hold_ms <= '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words under the reset hold time
    send_request(taat_pkg::FUNC_ADD, 32'h0000_0000, 32'd0);
    // expiry equal to now still blocks
    send_request(taat_pkg::FUNC_ADD, 32'h0000_0000, 32'd30000);
    send_request(taat_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd100);
    // delete of an absent key
    send_request(taat_pkg::FUNC_DEL, 32'h1234_5678, 32'd0);
    send_request(taat_pkg::FUNC_DEL, 32'hFFFF_FFFF, 32'd200);
    send_request(taat_pkg::FUNC_ADD, 32'h0000_0000, 32'd30001);
    // expiry wraps past the top of the time range
    send_request(taat_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(taat_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd0);
    send_request(taat_pkg::FUNC_ADD, 32'hFFFF_FFFF, 32'd30000);
    send_request(taat_pkg::FUNC_ADD, 32'hC0A8_0001, 32'd40000);
    send_request(taat_pkg::FUNC_ADD, 32'h0A00_0001, 32'd40000);
    // duplicate above an expired slot: the lower one is freed anyway
    send_request(taat_pkg::FUNC_ADD, 32'hC0A8_0001, 32'd65000);
    send_request(taat_pkg::FUNC_ADD, 32'h0A00_0001, 32'd65000);
    send_request(taat_pkg::FUNC_ADD, 32'h5555_AAAA, 32'd65000);
    send_request(taat_pkg::FUNC_DEL, 32'hC0A8_0001, 32'hFFFF_FFFF);
    send_request(taat_pkg::FUNC_ADD, 32'hAAAA_5555, 32'h8000_0000);
    send_request(taat_pkg::FUNC_DEL, 32'h0000_0000, 32'h7FFF_FFFF);
    send_request(taat_pkg::FUNC_ADD, 32'h0A00_0001, 32'd70001);
    wait_drain();

    // Random blocks: a new hold time each, idling pattern per third of the run
    for (int b = 0; b < BLOCK_COUNT; b++) begin
      if (b < 3) begin
        send_idle_pct = 37;
        recv_idle_pct = 46;
      end else if (b < 6) begin
        send_idle_pct = 46;
        recv_idle_pct = 37;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_hold(block_hold[b]);
      clock_ms = $urandom_range(1000);
      // back up the output side while the sender keeps offering
      if (b == 6) hold_off_req <= hold_off_req + 1;
      run_block(BLOCK_WORDS);
      wait_drain();
    end

    repeat (2 * SLOTS) @(posedge clk);
    if (sb.mismatches == 0 && sb.due_count() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/taat_pkg.sv
src/taat_entry_ram.sv
src/taat_ctrl.sv
src/timed_address_admission_table.sv
verif/tb_timed_address_admission_table.sv
